@@ hdl/gda_pkg.sv @@
// gda_pkg: shared types and constants for the gregorian date adder
// used by gda_decode, gda_split and gregorian_date_add_days; no dependencies
package gda_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned DOY_W    = 10;  // day of year plus offset, up to 877
  localparam int unsigned OFFSET_W = 9;

  localparam logic [YEAR_W-1:0]   YEAR_MIN         = 14'd1582;
  localparam logic [OFFSET_W-1:0] MAX_OFFSET_RESET = 9'd300;

  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_OFFSET_BIG = 3'd1;
  localparam logic [2:0] STATUS_YEAR_EARLY = 3'd2;
  localparam logic [2:0] STATUS_BAD_MONTH  = 3'd3;
  localparam logic [2:0] STATUS_BAD_DAY    = 3'd4;

  // first day of year of each month, non-leap year
  localparam logic [8:0] MONTH_FIRST [12] = '{
    9'd1, 9'd32, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [2:0]        status;
    logic [DOY_W-1:0]  doy;      // start day of year plus offset
    logic [YEAR_W-1:0] year;
    logic [2:0]        leap;     // leap flags of year, year+1, year+2
  } dec_t;

endpackage

@@ hdl/gregorian_date_add_days.sv @@
// Gregorian date plus day offset. An item enters an input register, is decoded (checks,
// leap flags, day of year plus offset) into a second register, and is split into month
// and day on its way to the result register, where out_valid rises with it. Up to three
// items are in flight, one item per cycle is taken, held back only by out_ready.
// max_offset resets to 300 and is written through cfg_wen/cfg_wdata.
// depends on gda_pkg, gda_decode, gda_split
module gregorian_date_add_days
  import gda_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [OFFSET_W-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [4:0]          start_day,
  input  logic [3:0]          start_month,
  input  logic [YEAR_W-1:0]   start_year,
  input  logic [OFFSET_W-1:0] offset_days,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          result_day,
  output logic [3:0]          result_month,
  output logic [YEAR_W-1:0]   result_year,
  output logic [2:0]          status
);

  logic [OFFSET_W-1:0] max_offset;

  logic                s1_valid;
  logic [4:0]          s1_day;
  logic [3:0]          s1_month;
  logic [YEAR_W-1:0]   s1_year;
  logic [OFFSET_W-1:0] s1_off;

  logic                s2_valid;
  dec_t                s2_dec;
  dec_t                dec_next;

  logic [4:0]          day_next;
  logic [3:0]          month_next;
  logic [YEAR_W-1:0]   year_next;
  logic [2:0]          status_next;

  logic out_load, s2_load, s1_load;

  assign out_load = !out_valid || out_ready;
  assign s2_load  = !s2_valid || out_load;
  assign s1_load  = !s1_valid || s2_load;
  assign in_ready = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_offset <= MAX_OFFSET_RESET;
    end else if (cfg_wen) begin
      max_offset <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= in_valid;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
      if (out_load) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_day   <= start_day;
      s1_month <= start_month;
      s1_year  <= start_year;
      s1_off   <= offset_days;
    end
    if (s2_load && s1_valid) begin
      s2_dec <= dec_next;
    end
    if (out_load && s2_valid) begin
      result_day   <= day_next;
      result_month <= month_next;
      result_year  <= year_next;
      status       <= status_next;
    end
  end

  gda_decode u_decode (
    .start_day   (s1_day),
    .start_month (s1_month),
    .start_year  (s1_year),
    .offset_days (s1_off),
    .max_offset  (max_offset),
    .dec         (dec_next)
  );

  gda_split u_split (
    .dec          (s2_dec),
    .result_day   (day_next),
    .result_month (month_next),
    .result_year  (year_next),
    .status       (status_next)
  );

endmodule

@@ hdl/gda_decode.sv @@
// gda_decode: input checks, leap flags and day of year plus offset
// combinational; depends on gda_pkg
module gda_decode
  import gda_pkg::*;
(
  input  logic [4:0]          start_day,
  input  logic [3:0]          start_month,
  input  logic [YEAR_W-1:0]   start_year,
  input  logic [OFFSET_W-1:0] offset_days,
  input  logic [OFFSET_W-1:0] max_offset,
  output dec_t                dec
);

  // 4/100/400 rule as: divisible by 4 and (not by 25, or by 16)
  // y mod 25 through a reciprocal multiply, exact for y below 2^15
  function automatic logic is_leap(input logic [YEAR_W:0] y);
    logic [27:0]     prod;
    logic [10:0]     q;
    logic [YEAR_W:0] q25;
    logic [YEAR_W:0] r;
    prod = y * 13'd5243;
    q    = prod[27:17];
    q25  = {q[10:0], 4'b0} + {1'b0, q[10:0], 3'b0} + {4'b0, q[10:0]};
    r    = y - q25;
    return (y[1:0] == 2'b00) && ((r != '0) || (y[3:0] == 4'b0000));
  endfunction

  logic [YEAR_W:0] year_ext;
  logic [3:0]      midx;
  logic            month_ok;
  logic            leap0;
  logic [4:0]      dim;
  logic [2:0]      status;
  logic [DOY_W-1:0] doy;

  assign year_ext = {1'b0, start_year};
  assign leap0    = is_leap(year_ext);
  assign month_ok = (start_month >= 4'd1) && (start_month <= 4'd12);
  assign midx     = month_ok ? (start_month - 4'd1) : 4'd0;
  assign dim      = MONTH_LEN[midx] + {4'b0, (midx == 4'd1) && leap0};

  always_comb begin
    if (offset_days > max_offset) begin
      status = STATUS_OFFSET_BIG;
    end else if (start_year < YEAR_MIN) begin
      status = STATUS_YEAR_EARLY;
    end else if (!month_ok) begin
      status = STATUS_BAD_MONTH;
    end else if ((start_day == 5'd0) || (start_day > dim)) begin
      status = STATUS_BAD_DAY;
    end else begin
      status = STATUS_OK;
    end
  end

  assign doy = {1'b0, MONTH_FIRST[midx]} + {5'b0, start_day} - 10'd1
             + {9'b0, (midx >= 4'd2) && leap0} + {1'b0, offset_days};

  assign dec.status = status;
  assign dec.doy    = doy;
  assign dec.year   = start_year;
  assign dec.leap   = {is_leap(year_ext + 15'd2), is_leap(year_ext + 15'd1), leap0};

endmodule

@@ hdl/gda_split.sv @@
// gda_split: year rollover and split of day of year into month and day
// combinational; depends on gda_pkg
module gda_split
  import gda_pkg::*;
(
  input  dec_t              dec,
  output logic [4:0]        result_day,
  output logic [3:0]        result_month,
  output logic [YEAR_W-1:0] result_year,
  output logic [2:0]        status
);

  logic [8:0]       len0, len1;
  logic             roll1, roll2;
  logic [DOY_W-1:0] n1, n2;
  logic             leap_f;
  logic [YEAR_W-1:0] year_f;
  logic [8:0]       start [12];
  logic [11:0]      ge;
  logic [3:0]       mi;
  logic [8:0]       day_w;

  assign len0  = 9'd365 + {8'b0, dec.leap[0]};
  assign len1  = 9'd365 + {8'b0, dec.leap[1]};
  assign roll1 = dec.doy > {1'b0, len0};
  assign n1    = roll1 ? (dec.doy - {1'b0, len0}) : dec.doy;
  assign roll2 = roll1 && (n1 > {1'b0, len1});
  assign n2    = roll2 ? (n1 - {1'b0, len1}) : n1;

  assign leap_f = roll2 ? dec.leap[2] : (roll1 ? dec.leap[1] : dec.leap[0]);
  assign year_f = dec.year + {12'b0, roll2, roll1 && !roll2};

  always_comb begin
    for (int m = 0; m < 12; m++) begin
      start[m] = MONTH_FIRST[m] + {8'b0, (m >= 2) && leap_f};
      ge[m]    = n2 >= {1'b0, start[m]};
    end
  end

  // last month whose first day is not past the day of year
  always_comb begin
    mi = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (ge[m]) begin
        mi = 4'(m);
      end
    end
  end

  assign day_w = n2[8:0] - start[mi] + 9'd1;

  always_comb begin
    status = dec.status;
    if (dec.status == STATUS_OK) begin
      result_day   = day_w[4:0];
      result_month = mi + 4'd1;
      result_year  = year_f;
    end else begin
      result_day   = '0;
      result_month = '0;
      result_year  = '0;
    end
  end

endmodule

@@ bench/gregorian_date_add_days_tb.sv @@
// gregorian_date_add_days_tb: self-checking bench for the date adder, directed dates then
// random dates under several max_offset settings with random idling on both channels
// depends on gda_pkg and gregorian_date_add_days
module gregorian_date_add_days_tb;
  import gda_pkg::*;

  localparam int unsigned FIRST_GREGORIAN_YEAR = 1582;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [4:0]          day;
    logic [3:0]          month;
    logic [YEAR_W-1:0]   year;
    logic [OFFSET_W-1:0] offset;
  } date_req_t;

  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
    logic [2:0]        status;
  } date_res_t;

  class date_scoreboard;
    date_res_t           expected_q[$];
    logic [OFFSET_W-1:0] max_offset;
    int                  fail_count;

    function new();
      max_offset = 9'd300;
      fail_count = 0;
    endfunction

    function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // mi is the zero-based month
    function int unsigned month_len(int unsigned mi, int unsigned y);
      int unsigned lens[12];
      lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      return lens[mi] + ((mi == 1 && leap_year(y)) ? 1 : 0);
    endfunction

    function int unsigned year_len(int unsigned y);
      return leap_year(y) ? 366 : 365;
    endfunction

    function date_res_t add_days(date_req_t r);
      date_res_t   res;
      int unsigned d, m, y, off, doy, mi;
      d = r.day;
      m = r.month;
      y = r.year;
      off = r.offset;
      res = '0;
      if (off > max_offset) res.status = STATUS_OFFSET_BIG;
      else if (y < FIRST_GREGORIAN_YEAR) res.status = STATUS_YEAR_EARLY;
      else if (m < 1 || m > 12) res.status = STATUS_BAD_MONTH;
      else if (d < 1 || d > month_len(m - 1, y)) res.status = STATUS_BAD_DAY;
      else begin
        res.status = STATUS_OK;
        doy = d;
        for (mi = 0; mi < m - 1; mi++) doy += month_len(mi, y);
        doy += off;
        while (doy > year_len(y)) begin
          doy -= year_len(y);
          y++;
        end
        mi = 0;
        while (mi < 11 && doy > month_len(mi, y)) begin
          doy -= month_len(mi, y);
          mi++;
        end
        res.day = 5'(doy);
        res.month = 4'(mi + 1);
        // years past 16383 wrap
        res.year = YEAR_W'(y);
      end
      return res;
    endfunction

    function void note_item(date_req_t r);
      expected_q.push_back(add_days(r));
    endfunction

    function void check_result(date_res_t got);
      date_res_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: day %0d month %0d year %0d status %0d",
                   got.day, got.month, got.year, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.day !== want.day || got.month !== want.month ||
          got.year !== want.year || got.status !== want.status) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("mismatch: expected %0d/%0d/%0d status %0d, got %0d/%0d/%0d status %0d",
                   want.day, want.month, want.year, want.status,
                   got.day, got.month, got.year, got.status);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wen = 1'b0;
  logic [OFFSET_W-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [4:0]          start_day = '0;
  logic [3:0]          start_month = '0;
  logic [YEAR_W-1:0]   start_year = '0;
  logic [OFFSET_W-1:0] offset_days = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [4:0]          result_day;
  logic [3:0]          result_month;
  logic [YEAR_W-1:0]   result_year;
  logic [2:0]          status;

  date_scoreboard sb;
  int unsigned    idle_max = 9;
  bit             hold_pending = 1'b0;
  int unsigned    quiet_cycles = 0;

  gregorian_date_add_days u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_day    (start_day),
    .start_month  (start_month),
    .start_year   (start_year),
    .offset_days  (offset_days),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_day   (result_day),
    .result_month (result_month),
    .result_year  (result_year),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_item(date_req_t'{start_day, start_month, start_year, offset_days});
      if (out_valid && out_ready)
        sb.check_result(date_res_t'{result_day, result_month, result_year, status});
      if (cfg_wen) sb.max_offset = cfg_wdata;
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stall per item, one long hold-off on request
  initial begin
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_pending) begin
        stall = HOLD_CYCLES;
        hold_pending = 1'b0;
      end else begin
        stall = $urandom_range(0, idle_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(date_req_t r);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_day <= r.day;
    start_month <= r.month;
    start_year <= r.year;
    offset_days <= r.offset;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_date(int unsigned d, int unsigned m, int unsigned y, int unsigned off);
    send_item(date_req_t'{5'(d), 4'(m), YEAR_W'(y), OFFSET_W'(off)});
  endtask

  function automatic date_req_t random_date(int unsigned limit);
    date_req_t   r;
    int unsigned len;
    if ($urandom_range(0, 9) == 0) r.year = YEAR_W'($urandom_range(0, 16383));
    else if ($urandom_range(0, 4) == 0) r.year = YEAR_W'(100 * $urandom_range(16, 99));
    else r.year = YEAR_W'($urandom_range(FIRST_GREGORIAN_YEAR, 9999));
    r.month = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                              : $urandom_range(1, 12));
    if (r.month >= 1 && r.month <= 12 && $urandom_range(0, 9) != 0) begin
      len = sb.month_len(r.month - 1, r.year);
      // month ends are worth extra weight
      r.day = 5'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
    end else begin
      r.day = 5'($urandom_range(0, 31));
    end
    r.offset = OFFSET_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                                      : $urandom_range(0, limit));
    return r;
  endfunction

  task automatic send_random_dates(int count, int unsigned limit);
    repeat (count) send_item(random_date(limit));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_max_offset(int unsigned value);
    cfg_wen <= 1'b1;
    cfg_wdata <= OFFSET_W'(value);
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limit of 300
    idle_max = 9;
    send_date(1, 1, 1582, 0);
    send_date(31, 12, 2023, 0);
    send_date(1, 1, 2023, 300);
    send_date(1, 1, 2023, 301);
    send_date(0, 0, 0, 511);        // offset check wins over all others
    send_date(15, 10, 1581, 5);
    send_date(0, 0, 1000, 0);       // year check wins over month
    send_date(10, 0, 2000, 1);
    send_date(10, 13, 2000, 1);
    send_date(0, 15, 2000, 1);      // month check wins over day
    send_date(0, 5, 2000, 1);
    send_date(31, 4, 2001, 0);
    send_date(29, 2, 1900, 0);
    send_date(29, 2, 2000, 0);
    send_date(30, 2, 2024, 0);
    send_date(28, 2, 2023, 1);
    send_date(28, 2, 2024, 1);
    send_date(31, 12, 2024, 1);
    send_date(31, 12, 16383, 1);    // year wraps to zero
    send_date(1, 3, 2100, 300);
    send_random_dates(120, 300);
    wait_drained();

    write_max_offset(0);
    send_date(31, 12, 9999, 0);
    send_date(31, 12, 9999, 1);
    send_random_dates(60, 0);
    wait_drained();

    // full rate with a long receiver hold-off to back up the pipeline
    write_max_offset(365);
    idle_max = 0;
    hold_pending = 1'b1;
    send_random_dates(150, 365);
    wait_drained();

    // above 365 the sum can roll over two years
    write_max_offset(511);
    idle_max = 9;
    send_date(31, 12, 2023, 511);
    send_date(31, 12, 16383, 511);
    send_date(31, 12, 2099, 511);
    send_random_dates(120, 511);
    wait_drained();

    write_max_offset(300);
    idle_max = 4;
    send_random_dates(100, 300);
    wait_drained();

    repeat (8) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
